// ----- hdl/dmw_pkg.sv -----
package dmw_pkg;

    // Register map, word index into the APB space
    localparam logic [2:0] REG_PULSES_PER_MPS    = 3'd0;
    localparam logic [2:0] REG_PULSE_LIMIT       = 3'd1;
    localparam logic [2:0] REG_LEFT_START_PULSE  = 3'd2;
    localparam logic [2:0] REG_RIGHT_START_PULSE = 3'd3;
    localparam logic [2:0] REG_INTAKE_LEVEL      = 3'd4;
    localparam logic [2:0] REG_TIMEOUT_TICKS     = 3'd5;

    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int LEVEL_W = 9;
    localparam int TICK_W  = 11;

    // Item kinds carried by the command field
    localparam logic CMD_VELOCITY = 1'b0;
    localparam logic CMD_TICK     = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [15:0] linear_speed;
        logic signed [15:0] turn_rate;
        logic               intake_request;
    } t_in_item;

    typedef struct packed {
        logic       left_dir_a;
        logic       left_dir_b;
        logic [7:0] left_duty;
        logic       right_dir_a;
        logic       right_dir_b;
        logic [7:0] right_duty;
        logic       intake_dir_a;
        logic [7:0] intake_duty;
        logic       timed_out;
    } t_out_item;

    typedef struct packed {
        logic [7:0] pulses_per_mps;
        logic [7:0] pulse_limit;
        logic [7:0] left_start_pulse;
        logic [7:0] right_start_pulse;
        logic [7:0] intake_level;
        logic [9:0] timeout_ticks;
    } t_cfg;

    // Mixer stage toward the drive stage
    typedef struct packed {
        logic                       valid;
        logic                       is_tick;
        logic                       intake_req;
        logic signed [LEVEL_W-1:0]  left_level;
        logic signed [LEVEL_W-1:0]  right_level;
    } t_mix;

endpackage

// ----- hdl/dmw_cfg_regs.sv -----
module dmw_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dmw_pkg::ADDR_W-1:0]   paddr,
    input  logic [dmw_pkg::DATA_W-1:0]   pwdata,
    output logic [dmw_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output dmw_pkg::t_cfg                o_cfg
);

    dmw_pkg::t_cfg r_cfg;
    logic [2:0]    s_index;
    logic          s_write;

    assign s_index = paddr[dmw_pkg::ADDR_W-1:2];
    assign s_write = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Write registers on the access phase; drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulses_per_mps    <= 8'd100;
            r_cfg.pulse_limit       <= 8'd128;
            r_cfg.left_start_pulse  <= 8'd0;
            r_cfg.right_start_pulse <= 8'd0;
            r_cfg.intake_level      <= 8'd128;
            r_cfg.timeout_ticks     <= 10'd100;
        end else if (s_write) begin
            unique case (s_index)
                dmw_pkg::REG_PULSES_PER_MPS:    r_cfg.pulses_per_mps    <= pwdata[7:0];
                dmw_pkg::REG_PULSE_LIMIT:       r_cfg.pulse_limit       <= pwdata[7:0];
                dmw_pkg::REG_LEFT_START_PULSE:  r_cfg.left_start_pulse  <= pwdata[7:0];
                dmw_pkg::REG_RIGHT_START_PULSE: r_cfg.right_start_pulse <= pwdata[7:0];
                dmw_pkg::REG_INTAKE_LEVEL:      r_cfg.intake_level      <= pwdata[7:0];
                dmw_pkg::REG_TIMEOUT_TICKS:     r_cfg.timeout_ticks     <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (s_index)
            dmw_pkg::REG_PULSES_PER_MPS:    prdata = 32'(r_cfg.pulses_per_mps);
            dmw_pkg::REG_PULSE_LIMIT:       prdata = 32'(r_cfg.pulse_limit);
            dmw_pkg::REG_LEFT_START_PULSE:  prdata = 32'(r_cfg.left_start_pulse);
            dmw_pkg::REG_RIGHT_START_PULSE: prdata = 32'(r_cfg.right_start_pulse);
            dmw_pkg::REG_INTAKE_LEVEL:      prdata = 32'(r_cfg.intake_level);
            dmw_pkg::REG_TIMEOUT_TICKS:     prdata = 32'(r_cfg.timeout_ticks);
            default:                        prdata = '0;
        endcase
    end

endmodule

// ----- hdl/dmw_mixer.sv -----
module dmw_mixer #(
    parameter int SPEED_FRAC_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s1_valid,
    input  dmw_pkg::t_in_item i_s1_data,
    input  logic              i_s2_open,
    input  dmw_pkg::t_cfg     i_cfg,
    output dmw_pkg::t_mix     o_mix
);

    localparam int SH = SPEED_FRAC_BITS + 1;
    // Scaled intermediates: 8b x 16b product, doubled, plus offset and carry
    localparam int MW = 8 + 16 + 4;
    localparam int PW = 9 + 16;
    localparam int LW = dmw_pkg::LEVEL_W;

    logic                 r_valid;
    logic                 r_tick;
    logic                 r_intake;
    logic                 r_xpos, r_xneg, r_zpos, r_zneg;
    logic signed [PW-1:0] r_px, r_pz;
    logic signed [MW-1:0] r_ls, r_rs;

    logic signed [8:0]    s_ppm;
    logic signed [PW-1:0] n_px, n_pz;

    logic signed [MW-1:0] s_a, s_w, s_hw;
    logic signed [MW-1:0] s_l1, s_r1, s_l2, s_r2;

    function automatic logic signed [MW-1:0] trunc_z(input logic signed [MW-1:0] v);
        logic signed [MW-1:0] mag;
        mag = v[MW-1] ? -v : v;
        mag = mag >>> SH;
        return v[MW-1] ? -mag : mag;
    endfunction

    function automatic logic signed [LW-1:0] clamp_lvl(input logic signed [MW-1:0] v,
                                                       input logic [7:0] limit);
        logic signed [MW-1:0] lim;
        lim = MW'({1'b0, limit});
        if (v > lim) begin
            return LW'(lim);
        end else if (v < -lim) begin
            return LW'(-lim);
        end
        return v[LW-1:0];
    endfunction

    // Form the speed and turn products from the input register
    assign s_ppm = $signed({1'b0, i_cfg.pulses_per_mps});
    assign n_px  = PW'(s_ppm * i_s1_data.linear_speed);
    assign n_pz  = PW'(s_ppm * i_s1_data.turn_rate);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_s2_open) begin
            r_valid <= i_s1_valid;
        end
    end

    // Hold products and signs for the mix stage
    always_ff @(posedge i_clk) begin
        if (i_s2_open && i_s1_valid) begin
            r_tick   <= (i_s1_data.command == dmw_pkg::CMD_TICK);
            r_intake <= i_s1_data.intake_request;
            r_xpos   <= !i_s1_data.linear_speed[15] && (i_s1_data.linear_speed != 16'sd0);
            r_xneg   <= i_s1_data.linear_speed[15];
            r_zpos   <= !i_s1_data.turn_rate[15] && (i_s1_data.turn_rate != 16'sd0);
            r_zneg   <= i_s1_data.turn_rate[15];
            r_px     <= n_px;
            r_pz     <= n_pz;
            r_ls     <= MW'(i_cfg.left_start_pulse) << SH;
            r_rs     <= MW'(i_cfg.right_start_pulse) << SH;
        end
    end

    assign s_a  = MW'(r_px) <<< 1;
    assign s_w  = MW'(r_pz) <<< 1;
    assign s_hw = MW'(r_pz);

    // Straight part, truncated toward zero
    always_comb begin
        if (r_xpos) begin
            s_l1 = trunc_z(r_ls + s_a);
            s_r1 = trunc_z(r_rs + s_a);
        end else if (r_xneg) begin
            s_l1 = trunc_z(s_a - r_ls);
            s_r1 = trunc_z(s_a - r_rs);
        end else begin
            s_l1 = '0;
            s_r1 = '0;
        end
    end

    // Turn correction: spin in place, or inner wheel at half weight
    always_comb begin
        s_l2 = s_l1;
        s_r2 = s_r1;
        if (r_zpos) begin
            if (r_xpos) begin
                s_r2 = trunc_z((s_r1 <<< SH) + s_w);
                s_l2 = trunc_z((s_l1 <<< SH) - s_hw);
            end else if (r_xneg) begin
                s_r2 = trunc_z((s_r1 <<< SH) - s_w);
                s_l2 = trunc_z((s_l1 <<< SH) + s_hw);
            end else begin
                s_l2 = trunc_z(-r_ls - s_w);
                s_r2 = trunc_z(r_rs + s_w);
            end
        end else if (r_zneg) begin
            if (r_xpos) begin
                s_l2 = trunc_z((s_l1 <<< SH) - s_w);
                s_r2 = trunc_z((s_r1 <<< SH) + s_hw);
            end else if (r_xneg) begin
                s_l2 = trunc_z((s_l1 <<< SH) + s_w);
                s_r2 = trunc_z((s_r1 <<< SH) - s_hw);
            end else begin
                s_l2 = trunc_z(r_ls - s_w);
                s_r2 = trunc_z(-r_rs + s_w);
            end
        end
    end

    assign o_mix.valid       = r_valid;
    assign o_mix.is_tick     = r_tick;
    assign o_mix.intake_req  = r_intake;
    assign o_mix.left_level  = clamp_lvl(s_l2, i_cfg.pulse_limit);
    assign o_mix.right_level = clamp_lvl(s_r2, i_cfg.pulse_limit);

endmodule

// ----- hdl/dmw_drive.sv -----
module dmw_drive (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dmw_pkg::t_mix      i_mix,
    input  dmw_pkg::t_cfg      i_cfg,
    input  logic               i_out_ready,
    output logic               o_take,
    output logic               o_out_valid,
    output dmw_pkg::t_out_item o_out_data
);

    localparam int LW = dmw_pkg::LEVEL_W;
    localparam int TW = dmw_pkg::TICK_W;

    logic signed [LW-1:0] r_left, r_right;
    logic                 r_intake_on;
    logic                 r_intake_driven;
    logic [TW-1:0]        r_ticks;
    logic                 r_out_valid;
    dmw_pkg::t_out_item   r_out;

    logic                 s_run;
    logic                 s_driven;
    logic                 s_tick_go;
    logic                 s_cmd_go;
    logic [9:0]           s_left_pins, s_right_pins;
    dmw_pkg::t_out_item   n_out;

    // Re-clamp a stored level and turn it into {dir_a, dir_b, duty}
    function automatic logic [9:0] wheel_pins(input logic signed [LW-1:0] lvl,
                                              input logic [7:0] limit);
        logic signed [LW-1:0] lim;
        logic signed [LW-1:0] v;
        logic signed [LW-1:0] mag;
        lim = $signed({1'b0, limit});
        v   = lvl;
        if (v > lim) begin
            v = lim;
        end else if (v < -lim) begin
            v = -lim;
        end
        mag = v[LW-1] ? -v : v;
        if (v == '0) begin
            return 10'd0;
        end
        return {v[LW-1], !v[LW-1], mag[7:0]};
    endfunction

    assign o_take    = i_mix.valid && (!i_mix.is_tick || !r_out_valid || i_out_ready);
    assign s_tick_go = o_take && i_mix.is_tick;
    assign s_cmd_go  = o_take && !i_mix.is_tick;
    assign s_run     = (r_ticks <= TW'(i_cfg.timeout_ticks));
    assign s_driven  = s_run ? r_intake_on : r_intake_driven;

    assign s_left_pins  = wheel_pins(r_left, i_cfg.pulse_limit);
    assign s_right_pins = wheel_pins(r_right, i_cfg.pulse_limit);

    // Build the tick result: drive wheels while running, else brake
    always_comb begin
        if (s_run) begin
            {n_out.left_dir_a, n_out.left_dir_b, n_out.left_duty}    = s_left_pins;
            {n_out.right_dir_a, n_out.right_dir_b, n_out.right_duty} = s_right_pins;
            n_out.timed_out = 1'b0;
        end else begin
            {n_out.left_dir_a, n_out.left_dir_b, n_out.left_duty}    = 10'd0;
            {n_out.right_dir_a, n_out.right_dir_b, n_out.right_duty} = 10'd0;
            n_out.timed_out = 1'b1;
        end
        n_out.intake_dir_a = s_driven;
        n_out.intake_duty  = s_driven ? i_cfg.intake_level : 8'd0;
    end

    // Update wheel state and watchdog
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left          <= '0;
            r_right         <= '0;
            r_intake_on     <= 1'b0;
            r_intake_driven <= 1'b0;
            r_ticks         <= '0;
        end else if (s_cmd_go) begin
            r_left      <= i_mix.left_level;
            r_right     <= i_mix.right_level;
            r_intake_on <= i_mix.intake_req;
            r_ticks     <= '0;
        end else if (s_tick_go && s_run) begin
            r_intake_driven <= r_intake_on;
            r_ticks         <= r_ticks + TW'(1);
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_tick_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tick_go) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- hdl/differential_drive_mixer_watchdog.sv -----
// Differential-drive mixer with command watchdog.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries velocity commands
// and timer ticks. A velocity command updates the stored wheel levels and the
// intake request and produces no result. Each tick produces one transaction on
// the output channel (o_out_valid / i_out_ready / o_out_data) with bridge pins
// and PWM levels for both wheels and the intake.
// A tick is carried to its result through the input register, the product register
// and the result register.
// Throughput: one item per cycle unless the receiver stalls; the two 8x16
// products sit in their own stage ahead of the mix and clamp stage.
// When the receiver stalls, the result register holds; commands keep flowing
// into the state, and a tick waits in the mix stage until the result register
// frees, and while it waits the input side stalls.
// Reset (synchronous, active low) empties the pipeline, zeroes wheel levels,
// intake state and the tick count, and loads the register defaults.
// The user writes registers over APB only while the block is idle, unenforced.
module differential_drive_mixer_watchdog #(
    parameter int SPEED_FRAC_BITS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  dmw_pkg::t_in_item           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output dmw_pkg::t_out_item          o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dmw_pkg::ADDR_W-1:0]  paddr,
    input  logic [dmw_pkg::DATA_W-1:0]  pwdata,
    output logic [dmw_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    dmw_pkg::t_cfg     s_cfg;
    dmw_pkg::t_mix     s_mix;
    logic              s_take;
    logic              s_s2_open;
    logic              s_in_go;
    logic              r_s1_valid;
    dmw_pkg::t_in_item r_s1_data;

    dmw_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (s_cfg)
    );

    // Advance the pipeline when the next stage empties
    assign s_s2_open  = !s_mix.valid || s_take;
    assign o_in_ready = !r_s1_valid || s_s2_open;
    assign s_in_go    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in_go) begin
            r_s1_data <= i_in_data;
        end
    end

    dmw_mixer #(
        .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
    ) u_mixer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (r_s1_valid),
        .i_s1_data  (r_s1_data),
        .i_s2_open  (s_s2_open),
        .i_cfg      (s_cfg),
        .o_mix      (s_mix)
    );

    dmw_drive u_drive (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mix       (s_mix),
        .i_cfg       (s_cfg),
        .i_out_ready (i_out_ready),
        .o_take      (s_take),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
